>>> rtl/core/assert_macros.svh
// Assertion macros shared by the deframer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Check a property on every rising edge outside reset.
`define SFLP_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("sflp assertion failed");

// Check that a condition never holds outside reset.
`define SFLP_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("sflp forbidden condition seen");

`else

`define SFLP_ASSERT(label, clk, rst_n, prop)
`define SFLP_NEVER(label, clk, rst_n, cond)

`endif

`endif

>>> rtl/core/sflp_pkg.sv
// Types and constants of the sync-word length-prefixed deframer.
`timescale 1ns / 1ps

package sflp_pkg;

    localparam int unsigned BYTE_W = 8;
    localparam int unsigned HALF_W = 16;
    localparam int unsigned SYNC_W = 32;

    // Body bytes that carry id and type ahead of the payload.
    localparam logic [HALF_W-1:0] HDR_BYTES = 16'd3;

    typedef enum logic [3:0] {
        PH_HUNT   = 4'b0001,
        PH_LEN_HI = 4'b0010,
        PH_LEN_LO = 4'b0100,
        PH_BODY   = 4'b1000
    } t_phase;

    typedef struct packed {
        logic [HALF_W-1:0] frame_id;
        logic [BYTE_W-1:0] frame_type;
        logic [BYTE_W-1:0] payload_byte;
        logic              has_data;
        logic              last;
    } t_result;

endpackage

>>> rtl/core/sync_length_frame_parser_core.sv
// Top level of the sync-word length-prefixed deframer.
`timescale 1ns / 1ps
`include "assert_macros.svh"

//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+--------------------------------
//  in      | sink      | i_in_valid / o_in_ready | i_rx_byte
//  out     | source    | o_out_valid / i_out_ready | o_frame_id, o_frame_type,
//          |           |                         | o_payload_byte, o_has_data, o_last
//  cfg     | sink      | i_cfg_valid / o_cfg_ready | i_cfg_data (sync word)
//
//  One byte per cycle sustained while the result register is not stalled. A
//  request sits in the input register while the decode runs, and the result
//  register loads the decoded result once it is free or draining. Reset is
//  synchronous and active low; it puts the hunt back to an empty window. When
//  the result register stalls, an empty input register still takes one more
//  byte, then ready drops until the result is taken. A sync word write waits
//  until the input register is empty.

module sync_length_frame_parser_core
    import sflp_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic [BYTE_W-1:0] i_rx_byte,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [HALF_W-1:0] o_frame_id,
    output logic [BYTE_W-1:0] o_frame_type,
    output logic [BYTE_W-1:0] o_payload_byte,
    output logic              o_has_data,
    output logic              o_last,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [SYNC_W-1:0] i_cfg_data
);

    // Sync word register; writes land only while the input register is empty.
    logic [SYNC_W-1:0] r_sync_word;

    // Input register: holds one accepted request.
    logic              r_in_valid;
    logic [BYTE_W-1:0] r_in_byte;

    // Result register.
    logic              r_out_valid;
    t_result           r_out;

    logic              w_stage_adv;
    logic              w_decode_adv;
    logic              w_res_valid;
    t_result           w_res;
    logic              w_in_stall;
    logic              w_out_stall;

    // Advance the decode stage whenever the result register is free or draining.
    assign w_stage_adv  = !r_out_valid || i_out_ready;
    assign w_decode_adv = r_in_valid && w_stage_adv;

    // Take a new request when the input register is empty or moves on.
    assign o_in_ready   = !r_in_valid || w_stage_adv;
    // Hold a sync word write until no request waits in the input register.
    assign o_cfg_ready  = !r_in_valid;

    assign w_in_stall   = r_in_valid && !w_stage_adv;
    assign w_out_stall  = r_out_valid && !i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sync_word <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_sync_word <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_byte <= i_rx_byte;
        end
    end

    sflp_deframer u_deframer (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_adv       (w_decode_adv),
        .i_byte      (r_in_byte),
        .i_sync_word (r_sync_word),
        .o_res_valid (w_res_valid),
        .o_res       (w_res)
    );

    // Load the result register; a byte without a result leaves it empty.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_stage_adv) begin
            r_out_valid <= w_decode_adv && w_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_decode_adv) begin
            r_out <= w_res;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_frame_id     = r_out.frame_id;
    assign o_frame_type   = r_out.frame_type;
    assign o_payload_byte = r_out.payload_byte;
    assign o_has_data     = r_out.has_data;
    assign o_last         = r_out.last;

    `SFLP_ASSERT(a_stalled_byte_held, i_clk, i_rst_n, w_in_stall |=> (r_in_valid && $stable(r_in_byte)))
    `SFLP_ASSERT(a_stalled_result_held, i_clk, i_rst_n, w_out_stall |=> (r_out_valid && $stable(r_out)))
    `SFLP_NEVER(a_no_drop_on_full, i_clk, i_rst_n, i_in_valid && o_in_ready && r_in_valid && !w_decode_adv)

endmodule

>>> rtl/core/sflp_deframer.sv
// Frame state and per-byte decode: sync hunt, length, header and payload.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module sflp_deframer
    import sflp_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_adv,
    input  logic [BYTE_W-1:0] i_byte,
    input  logic [SYNC_W-1:0] i_sync_word,
    output logic              o_res_valid,
    output t_result           o_res
);

    t_phase              r_phase,  n_phase;
    logic [23:0]         r_window, n_window;
    logic [1:0]          r_fill,   n_fill;
    logic [HALF_W-1:0]   r_len,    n_len;
    logic [HALF_W-1:0]   r_pos,    n_pos;
    logic [HALF_W-1:0]   r_id,     n_id;
    logic [BYTE_W-1:0]   r_type,   n_type;

    logic [SYNC_W-1:0]   w_cand;
    logic [HALF_W-1:0]   w_len_full;
    logic [HALF_W:0]     w_pos_inc;
    logic                w_done;
    logic                w_hdr_pos;
    logic                w_short;

    assign w_cand     = {r_window, i_byte};
    assign w_len_full = {r_len[HALF_W-1:BYTE_W], i_byte};
    assign w_pos_inc  = {1'b0, r_pos} + {{HALF_W{1'b0}}, 1'b1};
    assign w_done     = (w_pos_inc >= {1'b0, r_len});
    assign w_hdr_pos  = (r_pos < HDR_BYTES);
    assign w_short    = (r_len < HDR_BYTES);

    always_comb begin
        n_phase     = r_phase;
        n_window    = r_window;
        n_fill      = r_fill;
        n_len       = r_len;
        n_pos       = r_pos;
        n_id        = r_id;
        n_type      = r_type;
        o_res_valid = 1'b0;
        o_res       = '0;

        case (r_phase)
            PH_HUNT: begin
                if ((r_fill == 2'd3) && (w_cand == i_sync_word)) begin
                    n_phase  = PH_LEN_HI;
                    n_window = '0;
                    n_fill   = 2'd0;
                end else begin
                    n_window = w_cand[23:0];
                    if (r_fill != 2'd3) begin
                        n_fill = r_fill + 2'd1;
                    end
                end
            end
            PH_LEN_HI: begin
                n_len   = {i_byte, {BYTE_W{1'b0}}};
                n_phase = PH_LEN_LO;
            end
            PH_LEN_LO: begin
                n_len  = w_len_full;
                n_pos  = '0;
                n_id   = '0;
                n_type = '0;
                if (w_len_full == '0) begin
                    o_res_valid      = 1'b1;
                    o_res.last       = 1'b1;
                    n_phase          = PH_HUNT;
                    n_window         = '0;
                    n_fill           = 2'd0;
                end else begin
                    n_phase = PH_BODY;
                end
            end
            PH_BODY: begin
                if (r_pos == 16'd0) begin
                    n_id = {i_byte, {BYTE_W{1'b0}}};
                end else if (r_pos == 16'd1) begin
                    n_id = {r_id[HALF_W-1:BYTE_W], i_byte};
                end else if (r_pos == 16'd2) begin
                    n_type = i_byte;
                end else begin
                    o_res_valid        = 1'b1;
                    o_res.frame_id     = r_id;
                    o_res.frame_type   = r_type;
                    o_res.payload_byte = i_byte;
                    o_res.has_data     = 1'b1;
                    o_res.last         = w_done;
                end
                // Body no longer than the header: one empty result, id and type only if complete.
                if (w_hdr_pos && w_done) begin
                    o_res_valid = 1'b1;
                    o_res.last  = 1'b1;
                    if (!w_short) begin
                        o_res.frame_id   = r_id;
                        o_res.frame_type = i_byte;
                    end
                end
                if (w_done) begin
                    n_phase  = PH_HUNT;
                    n_window = '0;
                    n_fill   = 2'd0;
                    n_pos    = '0;
                end else begin
                    n_pos = w_pos_inc[HALF_W-1:0];
                end
            end
            default: begin
                n_phase = PH_HUNT;
                n_fill  = 2'd0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HUNT;
            r_fill  <= 2'd0;
            r_pos   <= '0;
        end else if (i_adv) begin
            r_phase <= n_phase;
            r_fill  <= n_fill;
            r_pos   <= n_pos;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_window <= n_window;
            r_len    <= n_len;
            r_id     <= n_id;
            r_type   <= n_type;
        end
    end

    `SFLP_ASSERT(a_fill_only_hunt, i_clk, i_rst_n, (r_phase != PH_HUNT) |-> (r_fill == 2'd0))
    `SFLP_NEVER(a_data_only_body, i_clk, i_rst_n, o_res_valid && o_res.has_data && (r_phase != PH_BODY))
    `SFLP_ASSERT(a_last_ends_frame, i_clk, i_rst_n, (i_adv && o_res_valid && o_res.last) |=> (r_phase == PH_HUNT))

endmodule

>>> tb/sv/deframer_checker.sv
// Checker for the sync-word deframer: predicts every result and compares it field by field.
`timescale 1ns / 1ps

module deframer_checker
    import sflp_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_in_ready,
    input  logic [BYTE_W-1:0] i_rx_byte,
    input  logic              i_out_valid,
    input  logic              i_out_ready,
    input  logic [HALF_W-1:0] i_frame_id,
    input  logic [BYTE_W-1:0] i_frame_type,
    input  logic [BYTE_W-1:0] i_payload_byte,
    input  logic              i_has_data,
    input  logic              i_last,
    input  logic              i_cfg_valid,
    input  logic              i_cfg_ready,
    input  logic [SYNC_W-1:0] i_cfg_data,
    output int                o_failures,
    output int                o_pending,
    output int                o_checked,
    output int                o_frames
);

    logic [SYNC_W-1:0] sync_word_q;
    t_phase            phase_q;
    logic [23:0]       window_q;
    logic [1:0]        fill_q;
    logic [HALF_W-1:0] length_q;
    logic [HALF_W-1:0] position_q;
    logic [HALF_W-1:0] id_q;
    logic [BYTE_W-1:0] type_q;
    t_result           deframed_results_q[$];

    // Back to an empty hunt window once a frame is over.
    function automatic void restart_hunt();
        phase_q    = PH_HUNT;
        window_q   = '0;
        fill_q     = '0;
        position_q = '0;
    endfunction

    // Advance the deframer by one byte; return 1 when the byte yields a result.
    function automatic bit deframe_byte(input logic [BYTE_W-1:0] b, output t_result res);
        logic [SYNC_W-1:0] cand;
        logic              closing;
        res          = '0;
        deframe_byte = 1'b0;
        case (phase_q)
            PH_HUNT: begin
                cand = {window_q, b};
                if (fill_q == 2'd3 && cand == sync_word_q) begin
                    phase_q  = PH_LEN_HI;
                    window_q = '0;
                    fill_q   = '0;
                end else begin
                    window_q = cand[23:0];
                    if (fill_q != 2'd3) fill_q = fill_q + 2'd1;
                end
            end
            PH_LEN_HI: begin
                length_q = {b, 8'h00};
                phase_q  = PH_LEN_LO;
            end
            PH_LEN_LO: begin
                length_q[7:0] = b;
                position_q    = '0;
                id_q          = '0;
                type_q        = '0;
                if (length_q == '0) begin
                    res.last     = 1'b1;
                    deframe_byte = 1'b1;
                    restart_hunt();
                end else begin
                    phase_q = PH_BODY;
                end
            end
            default: begin
                closing = (17'(position_q) + 17'd1) >= 17'(length_q);
                if (position_q >= HDR_BYTES) begin
                    res.frame_id     = id_q;
                    res.frame_type   = type_q;
                    res.payload_byte = b;
                    res.has_data     = 1'b1;
                    res.last         = closing;
                    deframe_byte     = 1'b1;
                end else begin
                    case (position_q)
                        16'd0:   id_q[15:8] = b;
                        16'd1:   id_q[7:0]  = b;
                        default: type_q     = b;
                    endcase
                    if (closing) begin
                        // bodies no longer than the header report an end of frame, bare if short
                        res.last     = 1'b1;
                        deframe_byte = 1'b1;
                        if (length_q >= HDR_BYTES) begin
                            res.frame_id   = id_q;
                            res.frame_type = type_q;
                        end
                    end
                end
                if (closing) restart_hunt();
                else position_q = position_q + 16'd1;
            end
        endcase
    endfunction

    task automatic report_mismatch(input string field, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("%0t ns: deframer mismatch on %s: got 0x%0h, expected 0x%0h",
                 $time, field, got, want);
        o_failures++;
    endtask

    always @(posedge i_clk) begin : watch
        t_result want;
        t_result fresh;
        bit      produced;
        if (!i_rst_n) begin
            sync_word_q = '0;
            restart_hunt();
            length_q    = '0;
            id_q        = '0;
            type_q      = '0;
            deframed_results_q.delete();
            o_failures  = 0;
            o_checked   = 0;
            o_frames    = 0;
            o_pending  <= 0;
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (deframed_results_q.size() == 0) begin
                    report_mismatch("result with none expected", 32'(i_frame_id), '0);
                end else begin
                    want = deframed_results_q.pop_front();
                    if (i_frame_id !== want.frame_id)
                        report_mismatch("frame_id", 32'(i_frame_id), 32'(want.frame_id));
                    if (i_frame_type !== want.frame_type)
                        report_mismatch("frame_type", 32'(i_frame_type),
                                        32'(want.frame_type));
                    if (i_payload_byte !== want.payload_byte)
                        report_mismatch("payload_byte", 32'(i_payload_byte),
                                        32'(want.payload_byte));
                    if (i_has_data !== want.has_data)
                        report_mismatch("has_data", 32'(i_has_data), 32'(want.has_data));
                    if (i_last !== want.last)
                        report_mismatch("last", 32'(i_last), 32'(want.last));
                    if (want.last) o_frames++;
                end
                o_checked++;
            end
            if (i_cfg_valid && i_cfg_ready) sync_word_q = i_cfg_data;
            if (i_in_valid && i_in_ready) begin
                produced = deframe_byte(i_rx_byte, fresh);
                if (produced) deframed_results_q = {deframed_results_q, fresh};
            end
            o_pending <= deframed_results_q.size();
        end
    end

endmodule

>>> tb/sv/tb_sync_length_frame_parser_core.sv
// Testbench top of the sync-word deframer: byte stimulus, sync word writes and the verdict.
`timescale 1ns / 1ps

// The checker beside the block predicts and compares every result; this module
// only produces traffic and decides pass or fail from the checker's counts.
//
// Flow of the run:
//   - hold reset, then hunt with the reset sync word of zero
//     (four zero bytes match once the window has filled, then an empty body)
//   - directed frames with a short body and with a header-only body
//   - start a frame, change the sync word halfway through its body, finish it
//   - random traffic: mostly well-formed frames with random content, plus
//     noise and sync words cut short, under three sync word settings, one of
//     them all ones, and one frame whose length has the high byte set
//   - the last random phase runs without any idle or stall cycles

module tb_sync_length_frame_parser_core;
    import sflp_pkg::*;

    // Request to result passes the input and result registers; leave some margin on top.
    localparam int unsigned DRAIN_CYCLES = 8;
    localparam int unsigned RESET_CYCLES = 11;
    localparam logic [SYNC_W-1:0] SYNC_DIRECTED = 32'hFF00_5AA5;
    localparam logic [SYNC_W-1:0] SYNC_ALL_ONES = 32'hFFFF_FFFF;

    logic              clk       = 1'b0;
    logic              rst_n     = 1'b0;
    logic              in_valid  = 1'b0;
    logic [BYTE_W-1:0] rx_byte   = '0;
    logic              out_ready = 1'b0;
    logic              cfg_valid = 1'b0;
    logic [SYNC_W-1:0] cfg_data  = '0;

    logic              in_ready;
    logic              out_valid;
    logic              cfg_ready;
    logic [HALF_W-1:0] frame_id;
    logic [BYTE_W-1:0] frame_type;
    logic [BYTE_W-1:0] payload_byte;
    logic              has_data;
    logic              last;

    int failures;
    int pending;
    int checked;
    int frames;

    // Idle and stall bursts are allowed while this is set.
    bit          bursts_on   = 1'b1;
    int unsigned bytes_sent  = 0;
    int unsigned sync_writes = 0;

    sync_length_frame_parser_core i_dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .o_in_ready     (in_ready),
        .i_rx_byte      (rx_byte),
        .o_out_valid    (out_valid),
        .i_out_ready    (out_ready),
        .o_frame_id     (frame_id),
        .o_frame_type   (frame_type),
        .o_payload_byte (payload_byte),
        .o_has_data     (has_data),
        .o_last         (last),
        .i_cfg_valid    (cfg_valid),
        .o_cfg_ready    (cfg_ready),
        .i_cfg_data     (cfg_data)
    );

    deframer_checker i_checker (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .i_in_ready     (in_ready),
        .i_rx_byte      (rx_byte),
        .i_out_valid    (out_valid),
        .i_out_ready    (out_ready),
        .i_frame_id     (frame_id),
        .i_frame_type   (frame_type),
        .i_payload_byte (payload_byte),
        .i_has_data     (has_data),
        .i_last         (last),
        .i_cfg_valid    (cfg_valid),
        .i_cfg_ready    (cfg_ready),
        .i_cfg_data     (cfg_data),
        .o_failures     (failures),
        .o_pending      (pending),
        .o_checked      (checked),
        .o_frames       (frames)
    );

    initial begin
        forever #2 clk = ~clk;
    end

    // Hard stop well beyond the slowest legal run.
    initial begin
        #2_000_000;
        $display("sync_length_frame_parser_core regression: fail");
        $finish;
    end

    // Result side: stall in random bursts, otherwise take every result.
    initial begin : result_sink
        int stall;
        stall = 0;
        forever begin
            @(negedge clk);
            if (stall > 0) begin
                stall--;
                out_ready <= 1'b0;
            end else if (bursts_on && $urandom_range(0, 4) == 0) begin
                stall = $urandom_range(0, 4);
                out_ready <= 1'b0;
            end else begin
                out_ready <= 1'b1;
            end
        end
    end

    // Offer one byte and hold it until the request is taken. An optional idle
    // burst goes ahead of it, so valid drops only in a step of its own.
    task automatic send_byte(input logic [BYTE_W-1:0] b);
        @(negedge clk);
        if (bursts_on && $urandom_range(0, 5) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(negedge clk);
        end
        in_valid <= 1'b1;
        rx_byte  <= b;
        do @(posedge clk); while (!in_ready);
        bytes_sent++;
    endtask

    task automatic send_random_bytes(input int unsigned count);
        repeat (count) send_byte(8'($urandom_range(0, 255)));
    endtask

    // Sync word first byte first, big-endian length, then a random body.
    task automatic send_frame(input logic [SYNC_W-1:0] sync, input logic [HALF_W-1:0] body_len);
        for (int k = 3; k >= 0; k--) send_byte(sync[8*k +: 8]);
        send_byte(body_len[15:8]);
        send_byte(body_len[7:0]);
        send_random_bytes(32'(body_len));
    endtask

    // Drop valid, let every expected result arrive, then give the block time
    // to finish any byte that produces nothing.
    task automatic settle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_sync_word(input logic [SYNC_W-1:0] value);
        settle();
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
        sync_writes++;
    endtask

    // Random traffic until the byte quota of this phase is used up.
    task automatic run_random(input int unsigned quota, input logic [SYNC_W-1:0] sync);
        int unsigned start;
        int unsigned choice;
        int unsigned cut;
        logic [HALF_W-1:0] body_len;
        start = bytes_sent;
        while (bytes_sent - start < quota) begin
            choice = $urandom_range(0, 19);
            if (choice < 14) begin
                // well-formed frame, a little noise ahead of it
                send_random_bytes($urandom_range(0, 3));
                if ($urandom_range(0, 9) == 0) body_len = 16'($urandom_range(13, 40));
                else body_len = 16'($urandom_range(0, 12));
                send_frame(sync, body_len);
            end else if (choice < 17) begin
                // sync word cut short by a wrong byte
                cut = $urandom_range(1, 3);
                for (int k = 0; k < cut; k++) send_byte(sync[31 - 8*k -: 8]);
                send_byte(sync[31 - 8*cut -: 8] ^ 8'h01);
            end else begin
                send_random_bytes($urandom_range(1, 6));
            end
        end
    endtask

    initial begin : stimulus
        logic [SYNC_W-1:0] sync_a;
        logic [SYNC_W-1:0] sync_c;

        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Reset sync word is zero: the fourth zero byte matches once three
        // bytes have filled the window, then a zero length closes at once.
        send_frame('0, 16'h0000);

        // Body shorter than the header, then a header-only body.
        write_sync_word(SYNC_DIRECTED);
        for (int k = 3; k >= 0; k--) send_byte(SYNC_DIRECTED[8*k +: 8]);
        send_byte(8'h00);
        send_byte(8'h02);
        send_byte(8'hFF);
        send_byte(8'h00);
        for (int k = 3; k >= 0; k--) send_byte(SYNC_DIRECTED[8*k +: 8]);
        send_byte(8'h00);
        send_byte(8'h03);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(8'h80);

        // Open a 7-byte body, swap the sync word mid-body, then finish it:
        // the new word only matters at the next hunt.
        for (int k = 3; k >= 0; k--) send_byte(SYNC_DIRECTED[8*k +: 8]);
        send_byte(8'h00);
        send_byte(8'h07);
        send_byte(8'h12);
        send_byte(8'h34);
        sync_a = $urandom();
        write_sync_word(sync_a);
        send_random_bytes(5);

        run_random(60, sync_a);

        // All-ones sync word, one long frame with the length high byte set.
        write_sync_word(SYNC_ALL_ONES);
        send_frame(SYNC_ALL_ONES, 16'h0100 + 16'($urandom_range(0, 15)));
        run_random(30, SYNC_ALL_ONES);

        // Last phase: full throughput, no idle and no stall.
        bursts_on = 1'b0;
        settle();
        sync_c = $urandom();
        write_sync_word(sync_c);
        run_random(40, sync_c);

        settle();
        $display("covered %0d request bytes under %0d sync word writes", bytes_sent, sync_writes);
        $display("checked %0d results, %0d of them closing a frame", checked, frames);
        if (failures == 0) begin
            $display("sync_length_frame_parser_core regression: pass");
        end else begin
            $display("sync_length_frame_parser_core regression: fail");
        end
        $finish;
    end

endmodule

>>> sim.f
+incdir+rtl/core
rtl/core/sflp_pkg.sv
rtl/core/sflp_deframer.sv
rtl/core/sync_length_frame_parser_core.sv
tb/sv/deframer_checker.sv
tb/sv/tb_sync_length_frame_parser_core.sv
